@@ rtl/skte_pkg.sv @@
// shared types and constants for the sorted key table engine
package skte_pkg;

    localparam int TableDepth = 64;
    localparam int KeyWidth   = 32;
    localparam int PayWidth   = 64;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_LIST   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_REM_RD,
        S_REM_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_LIST_RD,
        S_LIST_OUT,
        S_RESULT,
        S_WAIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     rd_en;        // read at index register
        logic     rd_prev;      // read at index-1 (insert shift)
        logic     rd_next;      // read at index+1 (remove shift)
        logic     wr_up;        // write read data to index (insert shift)
        logic     wr_new;       // write new record at index
        logic     wr_down;      // write read data to index (remove shift)
        logic     idx_init_cnt; // index = count
        logic     idx_zero;
        logic     idx_inc;
        logic     idx_dec;
        logic     srch_init;
        logic     srch_lo;      // first = mid + 1
        logic     srch_hi;      // last = mid - 1
        logic     cnt_inc;
        logic     cnt_dec;
        logic     save_hit;     // capture read record as result
        logic     out_load;
        status_t  out_status;
        logic     out_from_rec; // key/payload from captured record
        logic     out_last;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        func_t func;
        logic  full;
        logic  empty;
        logic  rd_less;      // read key < item key
        logic  rd_equal;
        logic  idx_zero;     // index == 0
        logic  idx_at_end;   // index + 1 >= count
        logic  srch_done;    // first > last
        logic  out_busy;
    } stat_t;

endpackage

@@ rtl/skte_ram.sv @@
// generic single-port ram with registered read
module skte_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule

@@ rtl/skte_datapath.sv @@
// table storage, index registers, compares and output register
module skte_datapath #(
    parameter int TableDepth = skte_pkg::TableDepth,
    parameter int KeyWidth   = skte_pkg::KeyWidth
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  skte_pkg::cmd_t           cmd,
    output skte_pkg::stat_t          stat,
    input  logic [1:0]               func,
    input  logic signed [KeyWidth-1:0] key,
    input  logic [skte_pkg::PayWidth-1:0] payload,
    output logic [1:0]               status,
    output logic signed [KeyWidth-1:0] rec_key,
    output logic [skte_pkg::PayWidth-1:0] rec_payload,
    output logic [6:0]               occupancy,
    output logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready
);
    localparam int AW = $clog2(TableDepth);
    localparam int CW = $clog2(TableDepth + 1);
    localparam int PW = skte_pkg::PayWidth;

    logic [1:0]          func_reg;
    logic [KeyWidth-1:0] key_reg;
    logic [PW-1:0]       pay_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW:0]         idx_reg;      // signed-ish index, extra bit
    logic [CW:0]         first_reg, last_reg;
    logic [KeyWidth-1:0] hit_key_reg;
    logic [PW-1:0]       hit_pay_reg;

    logic [AW-1:0]       addr;
    logic                we;
    logic [KeyWidth-1:0] wkey, rkey;
    logic [PW-1:0]       wpay, rpay;
    logic [CW:0]         mid;
    logic [CW+1:0]       mid_sum;
    logic [CW+1:0]       sfirst, slast;

    assign mid_sum = {1'b0, first_reg} + {1'b0, last_reg};
    assign mid     = mid_sum[CW+1:1];

    always_comb
    begin
        addr = idx_reg[AW-1:0];
        if (cmd.rd_prev)
        begin
            addr = AW'(idx_reg - 1'b1);
        end
        else if (cmd.rd_next)
        begin
            addr = AW'(idx_reg + 1'b1);
        end
        else if (cmd.srch_init || cmd.srch_lo || cmd.srch_hi)
        begin
            addr = mid[AW-1:0];
        end
    end

    assign we   = cmd.wr_up | cmd.wr_new | cmd.wr_down;
    assign wkey = cmd.wr_new ? key_reg : rkey;
    assign wpay = cmd.wr_new ? pay_reg : rpay;

    skte_ram #(.Width(KeyWidth), .Depth(TableDepth)) u_key_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wkey),
        .re    (cmd.rd_en),
        .rdata (rkey)
    );

    skte_ram #(.Width(PW), .Depth(TableDepth)) u_pay_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wpay),
        .re    (cmd.rd_en),
        .rdata (rpay)
    );

    // search probe address is mid; keep it in idx for the compare step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= func;
            key_reg  <= key;
            pay_reg  <= payload;
        end
        if (cmd.idx_init_cnt)
        begin
            idx_reg <= (CW+1)'(cnt_reg);
        end
        else if (cmd.idx_zero)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.srch_init)
        begin
            first_reg <= '0;
            last_reg  <= (CW+1)'(cnt_reg) - 1'b1;
        end
        else if (cmd.srch_lo)
        begin
            first_reg <= idx_reg + 1'b1;
        end
        else if (cmd.srch_hi)
        begin
            last_reg <= idx_reg - 1'b1;
        end
        if (cmd.srch_init || cmd.srch_lo || cmd.srch_hi)
        begin
            // probe index follows the updated bounds
            if (cmd.srch_init)
            begin
                idx_reg <= (CW+1)'(({1'b0, (CW+1)'(cnt_reg)} - 1'b1) >> 1);
            end
            else if (cmd.srch_lo)
            begin
                idx_reg <= (CW+1)'(({1'b0, idx_reg} + 1'b1 + {1'b0, last_reg}) >> 1);
            end
            else
            begin
                idx_reg <= (CW+1)'(({1'b0, first_reg} + {1'b0, idx_reg} - 1'b1) >> 1);
            end
        end
        if (cmd.save_hit)
        begin
            hit_key_reg <= rkey;
            hit_pay_reg <= rpay;
        end
        if (cmd.out_load)
        begin
            status      <= cmd.out_status;
            if (cmd.out_status == skte_pkg::ST_OK && func_reg == skte_pkg::FUNC_INSERT)
            begin
                rec_key     <= key_reg;
                rec_payload <= pay_reg;
            end
            else if (cmd.out_status == skte_pkg::ST_OK && func_reg == skte_pkg::FUNC_REMOVE)
            begin
                rec_key     <= hit_key_reg;
                rec_payload <= hit_pay_reg;
            end
            else
            begin
                rec_key     <= cmd.out_from_rec ? rkey : '0;
                rec_payload <= cmd.out_from_rec ? rpay : '0;
            end
            occupancy   <= 7'(cnt_reg);
            last        <= cmd.out_last;
        end
    end

    assign sfirst = {1'b0, first_reg};
    assign slast  = {last_reg[CW], last_reg};

    assign stat.func       = skte_pkg::func_t'(func_reg);
    assign stat.full       = (cnt_reg == CW'(TableDepth));
    assign stat.empty      = (cnt_reg == '0);
    assign stat.rd_less    = $signed(rkey) < $signed(key_reg);
    assign stat.rd_equal   = (rkey == key_reg);
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.idx_at_end = ((idx_reg + 1'b1) >= (CW+1)'(cnt_reg));
    assign stat.srch_done  = $signed(sfirst) > $signed(slast);
    assign stat.out_busy   = out_valid & ~out_ready;
endmodule

@@ rtl/skte_ctrl.sv @@
// operation sequencer for the sorted key table
module skte_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  skte_pkg::stat_t stat,
    output skte_pkg::cmd_t  cmd
);
    skte_pkg::state_t state_reg, state_next;
    skte_pkg::status_t res_reg, res_next;
    logic res_rec_reg, res_rec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= skte_pkg::S_IDLE;
            res_reg     <= skte_pkg::ST_OK;
            res_rec_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            res_rec_reg <= res_rec_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        res_rec_next = res_rec_reg;
        unique case (state_reg)
            skte_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = skte_pkg::S_DISPATCH;
                end
            end
            skte_pkg::S_DISPATCH:
            begin
                res_rec_next = 1'b0;
                unique case (stat.func)
                    skte_pkg::FUNC_INSERT:
                    begin
                        if (stat.full)
                        begin
                            res_next   = skte_pkg::ST_FULL;
                            state_next = skte_pkg::S_RESULT;
                        end
                        else
                        begin
                            state_next = skte_pkg::S_INS_RD;
                        end
                    end
                    skte_pkg::FUNC_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            res_next   = skte_pkg::ST_NOTFOUND;
                            state_next = skte_pkg::S_RESULT;
                        end
                        else
                        begin
                            state_next = skte_pkg::S_REM_RD;
                        end
                    end
                    skte_pkg::FUNC_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            res_next   = skte_pkg::ST_NOTFOUND;
                            state_next = skte_pkg::S_RESULT;
                        end
                        else
                        begin
                            state_next = skte_pkg::S_SRCH_RD;
                        end
                    end
                    default:
                    begin
                        if (stat.empty)
                        begin
                            res_next   = skte_pkg::ST_EMPTY;
                            state_next = skte_pkg::S_RESULT;
                        end
                        else
                        begin
                            state_next = skte_pkg::S_LIST_RD;
                        end
                    end
                endcase
            end
            skte_pkg::S_INS_RD:
            begin
                state_next = stat.idx_zero ? skte_pkg::S_INS_PUT : skte_pkg::S_INS_CMP;
            end
            skte_pkg::S_INS_CMP:
            begin
                // shift up while new key is below stored key
                if (!stat.rd_less && !stat.rd_equal)
                begin
                    state_next = skte_pkg::S_INS_RD;
                end
                else
                begin
                    state_next = skte_pkg::S_INS_PUT;
                end
            end
            skte_pkg::S_INS_PUT:
            begin
                res_next   = skte_pkg::ST_OK;
                state_next = skte_pkg::S_RESULT;
            end
            skte_pkg::S_REM_RD:
            begin
                state_next = skte_pkg::S_REM_CMP;
            end
            skte_pkg::S_REM_CMP:
            begin
                if (stat.rd_equal)
                begin
                    state_next = stat.idx_at_end ? skte_pkg::S_RESULT : skte_pkg::S_SHIFT_RD;
                    res_next   = skte_pkg::ST_OK;
                end
                else if (stat.idx_at_end)
                begin
                    res_next   = skte_pkg::ST_NOTFOUND;
                    state_next = skte_pkg::S_RESULT;
                end
                else
                begin
                    state_next = skte_pkg::S_REM_RD;
                end
            end
            skte_pkg::S_SHIFT_RD:
            begin
                state_next = skte_pkg::S_SHIFT_WR;
            end
            skte_pkg::S_SHIFT_WR:
            begin
                state_next = stat.idx_at_end ? skte_pkg::S_RESULT : skte_pkg::S_SHIFT_RD;
            end
            skte_pkg::S_SRCH_RD:
            begin
                state_next = skte_pkg::S_SRCH_CMP;
            end
            skte_pkg::S_SRCH_CMP:
            begin
                if (stat.rd_equal)
                begin
                    res_next     = skte_pkg::ST_OK;
                    res_rec_next = 1'b1;
                    state_next   = skte_pkg::S_RESULT;
                end
                else
                begin
                    state_next = skte_pkg::S_WAIT;
                end
            end
            skte_pkg::S_WAIT:
            begin
                // bounds updated: check for exhausted range
                if (stat.srch_done)
                begin
                    res_next   = skte_pkg::ST_NOTFOUND;
                    state_next = skte_pkg::S_RESULT;
                end
                else
                begin
                    state_next = skte_pkg::S_SRCH_RD;
                end
            end
            skte_pkg::S_LIST_RD:
            begin
                if (!stat.out_busy)
                begin
                    state_next = skte_pkg::S_LIST_OUT;
                end
            end
            skte_pkg::S_LIST_OUT:
            begin
                state_next = stat.idx_at_end ? skte_pkg::S_IDLE : skte_pkg::S_LIST_RD;
            end
            skte_pkg::S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = skte_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skte_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        cmd.out_status = skte_pkg::ST_OK;
        in_ready   = 1'b0;
        unique case (state_reg)
            skte_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            skte_pkg::S_DISPATCH:
            begin
                if (stat.func == skte_pkg::FUNC_INSERT)
                begin
                    cmd.idx_init_cnt = 1'b1;
                end
                else
                begin
                    cmd.idx_zero = 1'b1;
                end
            end
            skte_pkg::S_INS_RD:
            begin
                cmd.rd_en   = ~stat.idx_zero;
                cmd.rd_prev = 1'b1;
            end
            skte_pkg::S_INS_CMP:
            begin
                if (!stat.rd_less && !stat.rd_equal)
                begin
                    cmd.wr_up   = 1'b1;
                    cmd.idx_dec = 1'b1;
                end
            end
            skte_pkg::S_INS_PUT:
            begin
                cmd.wr_new  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            skte_pkg::S_REM_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            skte_pkg::S_REM_CMP:
            begin
                // count drops on the hit so the shift stops one short of the old end
                if (stat.rd_equal)
                begin
                    cmd.save_hit = 1'b1;
                    cmd.cnt_dec  = 1'b1;
                end
                else if (!stat.idx_at_end)
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            skte_pkg::S_SHIFT_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_next = 1'b1;
            end
            skte_pkg::S_SHIFT_WR:
            begin
                cmd.wr_down = 1'b1;
                cmd.idx_inc = 1'b1;
                if ((stat.idx_at_end) == 1'b0)
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            skte_pkg::S_SRCH_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            skte_pkg::S_SRCH_CMP:
            begin
                if (!stat.rd_equal)
                begin
                    cmd.srch_lo = stat.rd_less;
                    cmd.srch_hi = ~stat.rd_less;
                end
            end
            skte_pkg::S_LIST_RD:
            begin
                cmd.rd_en = ~stat.out_busy;
            end
            skte_pkg::S_LIST_OUT:
            begin
                cmd.out_load     = 1'b1;
                cmd.out_status   = skte_pkg::ST_OK;
                cmd.out_from_rec = 1'b1;
                cmd.out_last     = stat.idx_at_end;
                cmd.idx_inc      = 1'b1;
            end
            skte_pkg::S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_status   = res_reg;
                    cmd.out_from_rec = res_rec_reg;
                    cmd.out_last     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        // search bounds and the first probe index are set in the dispatch state
        if (state_reg == skte_pkg::S_DISPATCH && stat.func == skte_pkg::FUNC_SEARCH)
        begin
            cmd.srch_init = 1'b1;
            cmd.idx_zero  = 1'b0;
        end
    end
endmodule

@@ rtl/sorted_key_table_engine.sv @@
// sorted key table engine top level
// Usage: one operation word per input handshake (func, key, payload).
// insert keeps the table in ascending key order, equal keys in arrival
// order; remove deletes the oldest matching record and closes the gap;
// search is a binary search; list streams every record in key order.
// Each insert, remove or search gives one result word, list gives one
// word per record (last marks the final word) or one empty word.
// The key and payload memories are two single-port rams that share one
// address and write enable; a record is read or written as one unit.
// One operation is handled at a time; in_ready is high only while idle.
// Reset empties the table; stored records are not cleared, only the
// record count. The result sits in an output register: when the receiver
// stalls, the sequencer waits before loading the next result word.
module sorted_key_table_engine #(
    parameter int TableDepth = skte_pkg::TableDepth,
    parameter int KeyWidth   = skte_pkg::KeyWidth
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic signed [KeyWidth-1:0]    key,
    input  logic [skte_pkg::PayWidth-1:0] payload,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic signed [KeyWidth-1:0]    rec_key,
    output logic [skte_pkg::PayWidth-1:0] rec_payload,
    output logic [6:0]                    occupancy,
    output logic                          last
);
    skte_pkg::cmd_t  cmd;
    skte_pkg::stat_t stat;

    skte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    skte_datapath #(.TableDepth(TableDepth), .KeyWidth(KeyWidth)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .key         (key),
        .payload     (payload),
        .status      (status),
        .rec_key     (rec_key),
        .rec_payload (rec_payload),
        .occupancy   (occupancy),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );
endmodule

@@ sim/tb_sorted_key_table_engine.sv @@
// self-checking testbench for the sorted key table engine
`timescale 1ns / 1ps

module tb_sorted_key_table_engine;

    typedef struct packed {
        logic [1:0]                    func;
        logic [skte_pkg::KeyWidth-1:0] key;
        logic [skte_pkg::PayWidth-1:0] payload;
    } op_word_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic [skte_pkg::KeyWidth-1:0] rec_key;
        logic [skte_pkg::PayWidth-1:0] rec_payload;
        logic [6:0]                    occupancy;
        logic                          last;
    } res_word_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] func;
    logic signed [skte_pkg::KeyWidth-1:0] key;
    logic [skte_pkg::PayWidth-1:0] payload;
    logic out_valid;
    logic out_ready;
    logic [1:0] status;
    logic signed [skte_pkg::KeyWidth-1:0] rec_key;
    logic [skte_pkg::PayWidth-1:0] rec_payload;
    logic [6:0] occupancy;
    logic last;

    sorted_key_table_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .key(key), .payload(payload),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .rec_key(rec_key), .rec_payload(rec_payload),
        .occupancy(occupancy), .last(last)
    );

    op_word_t  pending_ops[$];
    res_word_t expected_words[$];
    int        error_count;
    int        ops_sent;
    int        words_seen;
    bit        hold_send;

    // predictor copy of the table
    logic signed [skte_pkg::KeyWidth-1:0] tbl_key[skte_pkg::TableDepth];
    logic [skte_pkg::PayWidth-1:0]        tbl_pay[skte_pkg::TableDepth];
    int                                   tbl_count;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic res_word_t make_word(skte_pkg::status_t st,
                                            logic [skte_pkg::KeyWidth-1:0] k,
                                            logic [skte_pkg::PayWidth-1:0] p, logic fin);
        res_word_t w;
        w.status      = st;
        w.rec_key     = k;
        w.rec_payload = p;
        w.occupancy   = tbl_count[6:0];
        w.last        = fin;
        return w;
    endfunction

    task automatic predict_table_op(op_word_t op);
        int pos;
        int first;
        int lastp;
        int mid;
        bit hit;
        logic signed [skte_pkg::KeyWidth-1:0] k;
        logic signed [skte_pkg::KeyWidth-1:0] rk;
        logic [skte_pkg::PayWidth-1:0] rp;
        k = op.key;
        hit = 1'b0;
        case (skte_pkg::func_t'(op.func))
            skte_pkg::FUNC_INSERT:
            begin
                if (tbl_count >= skte_pkg::TableDepth)
                    expected_words.push_back(make_word(skte_pkg::ST_FULL, '0, '0, 1'b1));
                else
                begin
                    pos = tbl_count;
                    while (pos > 0 && k < tbl_key[pos-1])
                    begin
                        tbl_key[pos] = tbl_key[pos-1];
                        tbl_pay[pos] = tbl_pay[pos-1];
                        pos--;
                    end
                    tbl_key[pos] = k;
                    tbl_pay[pos] = op.payload;
                    tbl_count++;
                    expected_words.push_back(make_word(skte_pkg::ST_OK, k, op.payload, 1'b1));
                end
            end
            skte_pkg::FUNC_REMOVE:
            begin
                for (int i = 0; i < tbl_count && !hit; i++)
                begin
                    if (tbl_key[i] == k)
                    begin
                        hit = 1'b1;
                        rk = tbl_key[i];
                        rp = tbl_pay[i];
                        for (int j = i; j + 1 < tbl_count; j++)
                        begin
                            tbl_key[j] = tbl_key[j+1];
                            tbl_pay[j] = tbl_pay[j+1];
                        end
                        tbl_count--;
                    end
                end
                if (hit)
                    expected_words.push_back(make_word(skte_pkg::ST_OK, rk, rp, 1'b1));
                else
                    expected_words.push_back(make_word(skte_pkg::ST_NOTFOUND, '0, '0, 1'b1));
            end
            skte_pkg::FUNC_SEARCH:
            begin
                first = 0;
                lastp = tbl_count - 1;
                while (first <= lastp && !hit)
                begin
                    mid = (first + lastp) / 2;
                    if (tbl_key[mid] < k)
                        first = mid + 1;
                    else if (tbl_key[mid] == k)
                        hit = 1'b1;
                    else
                        lastp = mid - 1;
                end
                if (hit)
                    expected_words.push_back(make_word(skte_pkg::ST_OK, tbl_key[mid],
                                                       tbl_pay[mid], 1'b1));
                else
                    expected_words.push_back(make_word(skte_pkg::ST_NOTFOUND, '0, '0, 1'b1));
            end
            default:
            begin
                if (tbl_count == 0)
                    expected_words.push_back(make_word(skte_pkg::ST_EMPTY, '0, '0, 1'b1));
                else
                    for (int i = 0; i < tbl_count; i++)
                        expected_words.push_back(make_word(skte_pkg::ST_OK, tbl_key[i],
                                                           tbl_pay[i], i + 1 == tbl_count));
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [skte_pkg::PayWidth-1:0] got,
                                   logic [skte_pkg::PayWidth-1:0] want);
        error_count++;
        $display("mismatch word %0d %s: got %h want %h", words_seen, what, got, want);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= '0;
            key      <= '0;
            payload  <= '0;
            send_gap <= 0;
        end
        else if (in_valid && !in_ready)
        begin
        end
        else
        begin
            if (in_valid)
            begin
                predict_table_op('{func, key, payload});
                ops_sent++;
            end
            if (send_gap > 0 || hold_send || pending_ops.size() == 0)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                op_word_t op;
                op = pending_ops.pop_front();
                in_valid <= 1'b1;
                func     <= op.func;
                key      <= op.key;
                payload  <= op.payload;
                send_gap <= pick_gap();
            end
        end
    end

    // monitor
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                res_word_t w;
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected word", '0, '0);
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (status !== w.status) report_mismatch("status", status, w.status);
                    if (rec_key !== w.rec_key) report_mismatch("rec_key", rec_key, w.rec_key);
                    if (rec_payload !== w.rec_payload)
                        report_mismatch("rec_payload", rec_payload, w.rec_payload);
                    if (occupancy !== w.occupancy)
                        report_mismatch("occupancy", occupancy, w.occupancy);
                    if (last !== w.last) report_mismatch("last", last, w.last);
                end
            end
            if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap  <= pick_gap();
            end
        end
    end

    task automatic queue_op(skte_pkg::func_t f, logic [skte_pkg::KeyWidth-1:0] k,
                            logic [skte_pkg::PayWidth-1:0] p);
        pending_ops.push_back('{f, k, p});
    endtask

    function automatic logic [skte_pkg::PayWidth-1:0] rand_pay();
        return {$urandom(), $urandom()};
    endfunction

    // sampled on the falling edge so driver and monitor updates have settled
    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
    endtask

    logic [skte_pkg::KeyWidth-1:0] key_pool[8];

    initial
    begin
        error_count = 0;
        ops_sent    = 0;
        words_seen  = 0;
        hold_send   = 1'b0;
        tbl_count   = 0;
        rst_n       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates
        queue_op(skte_pkg::FUNC_LIST, '0, '0);
        queue_op(skte_pkg::FUNC_REMOVE, 32'sd5, '0);
        queue_op(skte_pkg::FUNC_SEARCH, 32'sd5, '0);
        queue_op(skte_pkg::FUNC_INSERT, 32'h7fffffff, '1);
        queue_op(skte_pkg::FUNC_INSERT, 32'h80000000, '0);
        queue_op(skte_pkg::FUNC_INSERT, 32'sd0, 64'h5555_5555_5555_5555);
        queue_op(skte_pkg::FUNC_INSERT, 32'sd0, 64'haaaa_aaaa_aaaa_aaaa);
        queue_op(skte_pkg::FUNC_INSERT, 32'hffffffff, 64'h1);
        queue_op(skte_pkg::FUNC_LIST, '1, '1);
        queue_op(skte_pkg::FUNC_SEARCH, 32'h80000000, '0);
        queue_op(skte_pkg::FUNC_SEARCH, 32'h7fffffff, '0);
        queue_op(skte_pkg::FUNC_SEARCH, 32'sd3, '0);
        queue_op(skte_pkg::FUNC_REMOVE, 32'sd0, '0);
        queue_op(skte_pkg::FUNC_REMOVE, 32'sd7, '0);
        queue_op(skte_pkg::FUNC_LIST, '0, '0);
        wait_drained();

        // fill to capacity and overflow
        for (int i = 0; i < skte_pkg::TableDepth + 2; i++)
            queue_op(skte_pkg::FUNC_INSERT, $urandom_range(0, 15) - 8, rand_pay());
        queue_op(skte_pkg::FUNC_LIST, '0, '0);
        for (int i = 0; i < 3; i++)
            queue_op(skte_pkg::FUNC_SEARCH, $urandom_range(0, 15) - 8, '0);
        wait_drained();
        // sender is held off while the bench idles before the remove phase
        hold_send = 1'b1;
        repeat (20) @(posedge clk);
        hold_send = 1'b0;
        for (int i = 0; i < skte_pkg::TableDepth + 1; i++)
            queue_op(skte_pkg::FUNC_REMOVE, $urandom_range(0, 15) - 8, '0);
        queue_op(skte_pkg::FUNC_LIST, '0, '0);
        wait_drained();

        // random mix on a small key pool so hits are common
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        for (int i = 0; i < 250; i++)
        begin
            logic [skte_pkg::KeyWidth-1:0] k;
            int sel;
            k = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
            sel = $urandom_range(0, 19);
            if (sel < 8)
                queue_op(skte_pkg::FUNC_INSERT, k, rand_pay());
            else if (sel < 13)
                queue_op(skte_pkg::FUNC_REMOVE, k, rand_pay());
            else if (sel < 19)
                queue_op(skte_pkg::FUNC_SEARCH, k, rand_pay());
            else
                queue_op(skte_pkg::FUNC_LIST, k, rand_pay());
            if (i == 125)
            begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (200) @(posedge clk);

        $display("sent %0d operations, checked %0d result words", ops_sent, words_seen);
        $display("covered empty, full, duplicate keys, key extremes and random mix");
        if (error_count == 0 && expected_words.size() == 0)
            $display("tb_sorted_key_table_engine OK");
        else
            $display("tb_sorted_key_table_engine NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("tb_sorted_key_table_engine NOT OK");
        $finish;
    end

endmodule
